[sv/fcw_pkg.sv]
// shared widths, codes and request types of the fat12 cluster chain walker
`default_nettype none
package fcw_pkg;

	localparam int ADDR_W     = 13;
	localparam int BYTE_W     = 8;
	localparam int CLUSTER_W  = 12;
	localparam int SECTOR_W   = 16;
	localparam int STATUS_W   = 3;
	localparam int MODE_W     = 2;
	localparam int LIMIT_W    = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int TABLE_BYTES_DEF = 8192;
	localparam int MAX_RUN_DEF     = 64;

	// request modes
	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESUME = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_CONT  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_END   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RUN   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NONE  = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 1'd1;

	// fat12 entry markers
	localparam logic [CLUSTER_W-1:0] END_MARK     = 12'hFF8;
	localparam logic [CLUSTER_W-1:0] RESERVED_LOW = 12'hFF0;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = 13'h1000;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] off;
	} rd_req_t;

endpackage
`default_nettype wire

[sv/fcw_if.sv]
// request and result channel interfaces of the fat12 cluster chain walker
`default_nettype none
interface fcw_item_if;
	import fcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [ADDR_W-1:0]    byte_address;
	logic [BYTE_W-1:0]    byte_value;
	logic [CLUSTER_W-1:0] start_cluster;

	modport source (output valid, mode, byte_address, byte_value, start_cluster,
		input ready);
	modport sink (input valid, mode, byte_address, byte_value, start_cluster,
		output ready);
endinterface

interface fcw_result_if;
	import fcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CLUSTER_W-1:0] cluster;
	logic [SECTOR_W-1:0]  sector;
	logic [STATUS_W-1:0]  status;
	logic                 last;

	modport source (output valid, cluster, sector, status, last, input ready);
	modport sink (input valid, cluster, sector, status, last, output ready);
endinterface
`default_nettype wire

[sv/fcw_table.sv]
// fat table store split in even and odd byte banks, two bytes read per cycle
`default_nettype none
module fcw_table #(
	parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire fcw_pkg::wr_req_t       wr,
	input  wire fcw_pkg::rd_req_t       rd,
	output logic [fcw_pkg::BYTE_W-1:0]  b0,
	output logic [fcw_pkg::BYTE_W-1:0]  b1
);
	import fcw_pkg::*;

	localparam int HALF = (TABLE_BYTES + 1) / 2;
	localparam int BW   = $clog2(HALF);

	logic [BYTE_W-1:0] even_mem [HALF];
	logic [BYTE_W-1:0] odd_mem  [HALF];

	logic [ADDR_W:0]   off0;
	logic [ADDR_W:0]   off1;
	logic [BW-1:0]     even_idx;
	logic [BW-1:0]     odd_idx;
	logic              wr_in_range;

	logic [BYTE_W-1:0] even_s1;
	logic [BYTE_W-1:0] odd_s1;
	logic              par_s1;
	logic              oob0_s1;
	logic              oob1_s1;

	// byte off and off+1 always sit in different banks
	assign off0     = {1'b0, rd.off};
	assign off1     = off0 + 1'b1;
	assign even_idx = off1[BW:1];
	assign odd_idx  = off0[BW:1];
	assign wr_in_range = {1'b0, wr.addr} < (ADDR_W+1)'(TABLE_BYTES);

	// bank write and registered read
	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			if (wr.addr[0]) begin
				odd_mem[wr.addr[BW:1]] <= wr.data;
			end else begin
				even_mem[wr.addr[BW:1]] <= wr.data;
			end
		end
		if (rd.en) begin
			even_s1 <= even_mem[even_idx];
			odd_s1  <= odd_mem[odd_idx];
			par_s1  <= rd.off[0];
			oob0_s1 <= off0 >= (ADDR_W+1)'(TABLE_BYTES);
			oob1_s1 <= off1 >= (ADDR_W+1)'(TABLE_BYTES);
		end
	end

	// reorder by parity, bytes past the table read as zero
	assign b0 = oob0_s1 ? '0 : (par_s1 ? odd_s1 : even_s1);
	assign b1 = oob1_s1 ? '0 : (par_s1 ? even_s1 : odd_s1);

endmodule
`default_nettype wire

[sv/fcw_walker.sv]
// request sequencer: table loads, chain walk, run limit and result register
`default_nettype none
module fcw_walker #(
	parameter int MAX_RUN = fcw_pkg::MAX_RUN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [fcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fcw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	fcw_item_if.sink                         item,
	fcw_result_if.source                     result,
	output fcw_pkg::wr_req_t                 wr,
	output fcw_pkg::rd_req_t                 rd,
	input  wire logic [fcw_pkg::BYTE_W-1:0]  b0,
	input  wire logic [fcw_pkg::BYTE_W-1:0]  b1
);
	import fcw_pkg::*;

	localparam int RW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_EMIT} state_t;

	state_t               state_q;
	logic [CLUSTER_W-1:0] cur_q;
	logic [STATUS_W-1:0]  stat_q;
	logic [RW-1:0]        run_q;
	logic [CLUSTER_W-1:0] pend_cluster_q;
	logic                 pend_valid_q;
	logic                 out_valid_q;
	logic [CLUSTER_W-1:0] out_cluster_q;
	logic [SECTOR_W-1:0]  out_sector_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic                 out_last_q;
	logic [SECTOR_W-1:0]  data_start_q;
	logic [LIMIT_W-1:0]   limit_q;

	logic                 acc;
	logic                 out_free;
	logic                 bad_c;
	logic                 end_nx;
	logic                 run_full;
	logic                 emit;
	logic [CLUSTER_W-1:0] nx;
	logic [SECTOR_W-1:0]  sector_c;

	assign acc      = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;

	// bad cluster: free or reserved, reserved/bad markers, or past the limit
	assign bad_c = (cur_q < CLUSTER_W'(2))
		|| (cur_q >= RESERVED_LOW && cur_q < END_MARK)
		|| (cur_q < RESERVED_LOW && {1'b0, cur_q} >= limit_q);

	assign sector_c = data_start_q + SECTOR_W'(cur_q) - SECTOR_W'(2);

	// 12-bit entry from the two table bytes
	assign nx       = cur_q[0] ? {b1, b0[7:4]} : {b1[3:0], b0};
	assign end_nx   = nx >= END_MARK;
	assign run_full = run_q == RW'(MAX_RUN - 1);

	// table access requests
	assign wr.en   = acc && item.mode == MODE_LOAD;
	assign wr.addr = item.byte_address;
	assign wr.data = item.byte_value;
	assign rd.en   = state_q == S_READ && !bad_c;
	assign rd.off  = ADDR_W'(cur_q) + ADDR_W'(cur_q >> 1);

	assign emit = out_free && ((state_q == S_READ && bad_c) || state_q == S_EVAL
		|| state_q == S_EMIT);

	assign item.ready     = state_q == S_IDLE;
	assign result.valid   = out_valid_q;
	assign result.cluster = out_cluster_q;
	assign result.sector  = out_sector_q;
	assign result.status  = out_status_q;
	assign result.last    = out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= '0;
			limit_q      <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DATA_START: data_start_q <= cfg_wdata;
				CFG_LIMIT:      limit_q      <= cfg_wdata[LIMIT_W-1:0];
				default:        ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cur_q          <= '0;
			stat_q         <= ST_CONT;
			run_q          <= '0;
			pend_cluster_q <= '0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
			out_cluster_q  <= '0;
			out_sector_q   <= '0;
			out_status_q   <= ST_CONT;
			out_last_q     <= 1'b0;
		end else begin
			// result register fills on emit, drains when taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						run_q <= '0;
						case (item.mode)
							MODE_START: begin
								pend_valid_q   <= 1'b0;
								pend_cluster_q <= '0;
								cur_q          <= item.start_cluster;
								if (item.start_cluster == '0 || item.start_cluster >= END_MARK)
								begin
									stat_q  <= ST_EMPTY;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_READ;
								end
							end
							MODE_RESUME: begin
								if (pend_valid_q) begin
									cur_q          <= pend_cluster_q;
									pend_valid_q   <= 1'b0;
									pend_cluster_q <= '0;
									state_q        <= S_READ;
								end else begin
									cur_q   <= '0;
									stat_q  <= ST_NONE;
									state_q <= S_EMIT;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					if (!bad_c) begin
						state_q <= S_EVAL;
					end else if (out_free) begin
						out_cluster_q <= cur_q;
						out_sector_q  <= '0;
						out_status_q  <= ST_BAD;
						out_last_q    <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_EVAL: begin
					if (out_free) begin
						out_cluster_q <= cur_q;
						out_sector_q  <= sector_c;
						if (end_nx) begin
							out_status_q <= ST_END;
							out_last_q   <= 1'b1;
							state_q      <= S_IDLE;
						end else if (run_full) begin
							out_status_q   <= ST_RUN;
							out_last_q     <= 1'b1;
							pend_cluster_q <= nx;
							pend_valid_q   <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							out_status_q <= ST_CONT;
							out_last_q   <= 1'b0;
							cur_q        <= nx;
							run_q        <= run_q + 1'b1;
							state_q      <= S_READ;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_cluster_q <= cur_q;
						out_sector_q  <= '0;
						out_status_q  <= stat_q;
						out_last_q    <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a load request never raises a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item.mode == MODE_LOAD && !out_valid_q) |=> !out_valid_q)
		else $error("result raised by a table load");

	// only the final result of a request is not a continue
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_status_q != ST_CONT)))
		else $error("last flag disagrees with status");

	// run limit result leaves a pending walk behind
	a_run_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == S_EVAL && !end_nx && run_full) |=> pend_valid_q)
		else $error("run limit without pending walk");

	// results without a data cluster carry sector zero
	a_zero_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_BAD || out_status_q == ST_EMPTY
		|| out_status_q == ST_NONE)) |-> out_sector_q == '0)
		else $error("nonzero sector on a status-only result");

endmodule
`default_nettype wire

[sv/fat12_cluster_chain_walker.sv]
// fat12 cluster chain walker: banked table store plus walk sequencer
// a table load is written as it is taken; a walk gives its clusters one at a time,
// each set by a table read (address cycle, then registered data cycle) and held back
// while the result register is full; new requests wait until the walk's last result
// is registered; status-only results (empty, bad start, nothing pending) need no read
// reset sets the sequencer, pending walk and registers; table bytes stay undefined
`default_nettype none
module fat12_cluster_chain_walker #(
	parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
	parameter int MAX_RUN     = fcw_pkg::MAX_RUN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fcw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	fcw_item_if.sink                            item,
	fcw_result_if.source                        result
);
	import fcw_pkg::*;

	wr_req_t           wr;
	rd_req_t           rd;
	logic [BYTE_W-1:0] b0;
	logic [BYTE_W-1:0] b1;

	fcw_table #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_table (
		.clk(clk),
		.wr (wr),
		.rd (rd),
		.b0 (b0),
		.b1 (b1)
	);

	fcw_walker #(
		.MAX_RUN(MAX_RUN)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item     (item),
		.result   (result),
		.wr       (wr),
		.rd       (rd),
		.b0       (b0),
		.b1       (b1)
	);

endmodule
`default_nettype wire
